// ===== hw/rtl/aes128d_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 decrypt package
// Shared types, constants and byte functions for the AES-128 decrypt core.
// ----------------------------------------------------------------------------
package aes128d_pkg;

   localparam int NUM_COLS = 4;

   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;

   typedef logic [7:0]  byte_type;
   typedef logic [31:0] word_type;
   typedef logic [127:0] block_type;

   function automatic byte_type xtime(input byte_type a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic byte_type sbox(input byte_type x);
      byte_type tbl [256];
      tbl = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = tbl[x];
   endfunction

   function automatic byte_type inv_sbox(input byte_type x);
      byte_type tbl [256];
      tbl = '{
         8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
         8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
         8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
         8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
         8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
         8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
         8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
         8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
         8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
         8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
         8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
         8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
         8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
         8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
         8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
         8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      inv_sbox = tbl[x];
   endfunction

endpackage

// ===== hw/rtl/aes128d_lane.sv =====
// ----------------------------------------------------------------------------
// AES-128 decrypt column lane
// One state column: optional InvMixColumns after key addition.
// ----------------------------------------------------------------------------
module aes128d_lane
   import aes128d_pkg::*;
(
   input  word_type col_i,
   input  word_type key_i,
   input  logic     mix_i,
   output word_type col_o
);

   word_type  a;
   byte_type  a0, a1, a2, a3;
   byte_type  x0 [4];
   byte_type  x1 [4];
   byte_type  x2 [4];
   byte_type  m9 [4];
   byte_type  mb [4];
   byte_type  md [4];
   byte_type  me [4];

   always_comb begin
      a  = col_i ^ key_i;
      a0 = a[31:24];
      a1 = a[23:16];
      a2 = a[15:8];
      a3 = a[7:0];
      x0 = '{a0, a1, a2, a3};
      for (int i = 0; i < 4; i++) begin
         x1[i] = xtime(x0[i]);
         x2[i] = xtime(x1[i]);
         m9[i] = xtime(x2[i]) ^ x0[i];
         mb[i] = m9[i] ^ x1[i];
         md[i] = m9[i] ^ x2[i];
         me[i] = xtime(x2[i]) ^ x2[i] ^ x1[i];
      end
      if (mix_i) begin
         col_o = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                  m9[0] ^ me[1] ^ mb[2] ^ md[3],
                  md[0] ^ m9[1] ^ me[2] ^ mb[3],
                  mb[0] ^ md[1] ^ m9[2] ^ me[3]};
      end else begin
         col_o = a;
      end
   end

endmodule

// ===== hw/rtl/aes128d_merge.sv =====
// ----------------------------------------------------------------------------
// AES-128 decrypt merge stage
// Combines the lane columns through InvShiftRows and InvSubBytes.
// ----------------------------------------------------------------------------
module aes128d_merge
   import aes128d_pkg::*;
(
   input  block_type state_i,
   output block_type state_o
);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            state_o[127 - 8 * (4 * c + r) -: 8] =
               inv_sbox(state_i[127 - 8 * (4 * ((c - r + 4) % 4) + r) -: 8]);
         end
      end
   end

endmodule

// ===== hw/rtl/aes128d_keyexp.sv =====
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Expands the cipher key one round a cycle into the round key store.
// ----------------------------------------------------------------------------
module aes128d_keyexp
   import aes128d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start_i,
   input  block_type  key_i,
   input  logic [3:0] rd_round_i,
   output block_type  rd_key_o,
   output logic       busy_o
);

   block_type  store [11];
   block_type  cur_ff, cur_in;
   logic [3:0] cnt_ff, cnt_in;
   byte_type   rcon_ff, rcon_in;
   logic       busy_ff, busy_in;
   word_type   t;
   word_type   w0, w1, w2, w3;

   always_comb begin
      t  = {sbox(cur_ff[23:16]) ^ rcon_ff, sbox(cur_ff[15:8]), sbox(cur_ff[7:0]),
            sbox(cur_ff[31:24])};
      w0 = cur_ff[127:96] ^ t;
      w1 = cur_ff[95:64] ^ w0;
      w2 = cur_ff[63:32] ^ w1;
      w3 = cur_ff[31:0] ^ w2;
      cur_in  = cur_ff;
      cnt_in  = cnt_ff;
      rcon_in = rcon_ff;
      busy_in = busy_ff;
      if (start_i) begin
         cur_in  = key_i;
         cnt_in  = 4'd0;
         rcon_in = 8'h01;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cur_in  = {w0, w1, w2, w3};
         rcon_in = xtime(rcon_ff);
         cnt_in  = cnt_ff + 4'd1;
         if (cnt_ff == 4'd10) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      cur_ff  <= cur_in;
      rcon_ff <= rcon_in;
      if (busy_ff && !start_i) begin
         store[cnt_ff] <= cur_ff;
      end
   end

   assign rd_key_o = store[rd_round_i];
   assign busy_o   = busy_ff;

endmodule

// ===== hw/rtl/aes128_block_decrypt_core.sv =====
// ----------------------------------------------------------------------------
// AES-128 block decrypt core
// ECB AES-128 decryption with four column lanes and an in-core key schedule.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports
//  req     | in        | req_valid, req_ready, req_cipher_high, req_cipher_low
//  rsp     | out       | rsp_valid, rsp_ready, rsp_plain_high, rsp_plain_low
//  csr     | in        | csr_we, csr_index, csr_wdata
//
// A block passes through the shared round datapath once per round key.
// A key write starts an expansion; blocks wait until it ends.
// Reset is synchronous and clears all control state.
// A finished block stays in the output register until its transfer.
// A new block may start while a result waits; its last round holds until
// the output register is free.
// ----------------------------------------------------------------------------
module aes128_block_decrypt_core
   import aes128d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_cipher_high,
   input  logic [63:0] req_cipher_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_plain_high,
   output logic [63:0] rsp_plain_low,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   block_type  key_ff, key_in;
   block_type  st_ff, st_in;
   block_type  mixed, merged, rkey;
   logic [3:0] rnd_ff, rnd_in;
   logic       run_ff, run_in;
   logic       ov_ff, ov_in;
   block_type  out_ff, out_in;
   logic       kbusy;
   logic       mix;

   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         if (csr_index == CSR_KEY_HIGH[0:0]) key_in[127:64] = csr_wdata;
         else key_in[63:0] = csr_wdata;
      end
   end

   aes128d_keyexp u_keyexp (
      .clock      (clock),
      .reset      (reset),
      .start_i    (csr_we),
      .key_i      (key_in),
      .rd_round_i (rnd_ff),
      .rd_key_o   (rkey),
      .busy_o     (kbusy)
   );

   assign mix = (rnd_ff != 4'd10) && (rnd_ff != 4'd0);

   for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
      aes128d_lane u_lane (
         .col_i (st_ff[127 - 32 * c -: 32]),
         .key_i (rkey[127 - 32 * c -: 32]),
         .mix_i (mix),
         .col_o (mixed[127 - 32 * c -: 32])
      );
   end

   aes128d_merge u_merge (
      .state_i (mixed),
      .state_o (merged)
   );

   assign req_ready = !run_ff && !kbusy && !csr_we;

   always_comb begin
      st_in  = st_ff;
      rnd_in = rnd_ff;
      run_in = run_ff;
      ov_in  = ov_ff;
      out_in = out_ff;
      if (rsp_valid && rsp_ready) ov_in = 1'b0;
      if (req_valid && req_ready) begin
         st_in  = {req_cipher_high, req_cipher_low};
         rnd_in = 4'd10;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rnd_ff != 4'd0) begin
            st_in  = merged;
            rnd_in = rnd_ff - 4'd1;
         end else if (!ov_ff || rsp_ready) begin
            run_in = 1'b0;
            ov_in  = 1'b1;
            out_in = mixed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         run_ff <= 1'b0;
         ov_ff  <= 1'b0;
         rnd_ff <= 4'd0;
      end else begin
         key_ff <= key_in;
         run_ff <= run_in;
         ov_ff  <= ov_in;
         rnd_ff <= rnd_in;
      end
      st_ff  <= st_in;
      out_ff <= out_in;
   end

   assign rsp_valid      = ov_ff;
   assign rsp_plain_high = out_ff[127:64];
   assign rsp_plain_low  = out_ff[63:0];

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_ff)))
      else $error("pending result changed before its transfer");
   a_done : assert property (@(posedge clock) disable iff (reset)
      (run_ff && rnd_ff == 4'd0 && (!ov_ff || rsp_ready)) |=> (ov_ff && !run_ff))
      else $error("last round did not load the output register");
   a_start : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (run_ff && rnd_ff == 4'd10))
      else $error("accepted block did not start at the last round key");

endmodule
